### rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 4;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Commands from the controller to the output register.
  typedef struct packed {
    logic             load;  // capture status and occupancy, clear data
    logic             show;  // result is complete now, raise valid
    logic             fill;  // memory read data is ready, capture it and raise valid
    status_t          status;
    logic [OCC_W-1:0] occ;
  } rslt_t;

endpackage

`default_nettype wire

### rtl/core/cdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_WIDTH-1:0]    wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic [VALUE_W-1:0]       in_value,
  input  wire logic                     out_free,
  output logic                          in_ready,
  output rslt_t                         rslt,
  output logic                          ram_we,
  output logic      [$clog2(DEPTH)-1:0] ram_waddr,
  output logic      [DATA_WIDTH-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic      [$clog2(DEPTH)-1:0] ram_raddr
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int EW   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int OCCX = (CW > OCC_W) ? CW : OCC_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t        state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          accept;
  logic          rd_issue;
  logic          empty;
  logic          full;
  logic [IW-1:0] head_prev, head_next, tail_prev, tail_next;
  logic [EW-1:0] value_ext;
  logic [OCCX-1:0] occ_ext;
  status_t       status;

  assign accept    = in_valid && in_ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == FULL_CNT);
  assign head_prev = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign head_next = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;
  assign tail_next = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign value_ext = EW'(in_value);
  assign occ_ext   = OCCX'(count_nxt);

  // Indexes and count move at the accept edge. A push writes the memory at
  // that edge; a later read is always issued at a later edge, so it sees the
  // written entry without forwarding.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    status    = ST_OK;
    rd_issue  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = value_ext[DATA_WIDTH-1:0];
    ram_re    = 1'b0;
    ram_raddr = head_r;
    if (accept) begin
      unique case (in_func)
        OP_PUSH_FRONT: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_prev;
            head_nxt  = head_prev;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_PUSH_REAR: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            tail_nxt  = tail_next;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_issue  = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = head_r;
            head_nxt  = head_next;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_POP_REAR: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_issue  = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = tail_prev;
            tail_nxt  = tail_prev;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_PEEK_FRONT: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_issue  = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = head_r;
          end
        end
        OP_PEEK_REAR: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            rd_issue  = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = tail_prev;
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && rd_issue) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    rslt.fill   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = out_free;
      end
      S_READ: begin
        rslt.fill = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    rslt.load   = accept;
    rslt.show   = accept && !rd_issue;
    rslt.status = status;
    rslt.occ    = occ_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/circular_deque.sv
// Double-ended queue of DEPTH elements held in a circular memory.
// Input channel (in_valid/in_ready): one beat carries an operation in_func
// (push front, push rear, pop front, pop rear, peek front, peek rear) and
// an element in_value used only by pushes. Codes 6 and 7 do nothing.
// Result channel (out_valid/out_ready): one beat per input beat, carrying
// out_data (popped or peeked element, else zero), out_status (ok, full,
// empty) and out_occupancy (element count after the operation).
// A push, a rejected operation or an unused code shows its result in the
// cycle after acceptance; a pop or peek that reaches the memory shows it
// after its registered memory read, and no beat is taken during that read.
// Throughput: one push per cycle while the receiver takes each result.
// A new beat is taken once the previous result is in the output register
// and that register is empty or being taken in the same cycle; while the
// receiver stalls, the result holds and in_ready stays low.
// Reset empties the deque (indexes and count to zero) and drops any pending
// result; the memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic        [FUNC_W-1:0]  in_func,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed      [VALUE_W-1:0] out_data,
  output logic             [STAT_W-1:0]  out_status,
  output logic             [OCC_W-1:0]   out_occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  rslt_t                 rslt;
  logic                  out_free;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [EW-1:0]         rdata_ext;

  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_data_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [OCC_W-1:0]      out_occ_r;

  assign out_free  = !out_valid_r || out_ready;
  assign rdata_ext = EW'(ram_rdata);

  cdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_value  (in_value),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .rslt      (rslt),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  cdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rslt.show || rslt.fill) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rslt.load) begin
      out_status_r <= rslt.status;
      out_occ_r    <= rslt.occ;
      out_data_r   <= '0;
    end
    if (rslt.fill) begin
      out_data_r <= rdata_ext[VALUE_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

### verif/tb_circular_deque.sv
`timescale 1ns / 1ps

module tb_circular_deque;
  import cdq_pkg::*;

  localparam int DEQ_DEPTH = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [FUNC_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
  } deq_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] data;
    status_t                   status;
    logic [OCC_W-1:0]          occ;
  } deq_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_data;
  logic [STAT_W-1:0] out_status;
  logic [OCC_W-1:0] out_occupancy;

  deq_op_t ops_to_send[$];
  deq_rsp_t results_due[$];
  logic signed [VALUE_W-1:0] deque_mirror[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bad_results = 0;
  int quiet_cycles = 0;

  circular_deque #(
    .DEPTH(DEQ_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .out_status(out_status),
    .out_occupancy(out_occupancy)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one operation to the mirror of the deque and returns its result.
  function automatic deq_rsp_t apply_deque_op(logic [FUNC_W-1:0] func,
                                              logic signed [VALUE_W-1:0] value);
    deq_rsp_t r;
    r.data = '0;
    r.status = ST_OK;
    case (func)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (deque_mirror.size() >= DEQ_DEPTH) begin
          r.status = ST_FULL;
        end else if (func == OP_PUSH_FRONT) begin
          deque_mirror.push_front(value);
        end else begin
          deque_mirror.push_back(value);
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (deque_mirror.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          case (func)
            OP_POP_FRONT: r.data = deque_mirror.pop_front();
            OP_POP_REAR: r.data = deque_mirror.pop_back();
            OP_PEEK_FRONT: r.data = deque_mirror[0];
            default: r.data = deque_mirror[$];
          endcase
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(deque_mirror.size());
    return r;
  endfunction

  task automatic queue_op(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] value);
    deq_op_t op;
    op.func = func;
    op.value = value;
    ops_to_send.push_back(op);
  endtask

  // Runs of operations lean toward pushes, toward pops, or neither, so that
  // the deque keeps swinging between empty and full.
  task automatic queue_random_ops(int n);
    int lean;
    int push_pct;
    logic [FUNC_W-1:0] func;
    logic signed [VALUE_W-1:0] value;
    lean = 0;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 24 == 0) begin
        lean = $urandom_range(2);
        push_pct = (lean == 0) ? 72 : (lean == 1) ? 28 : 50;
      end
      if ($urandom_range(99) < 3) begin
        func = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
      end else if ($urandom_range(99) < push_pct) begin
        func = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        case ($urandom_range(5))
          0, 1: func = OP_POP_FRONT;
          2, 3: func = OP_POP_REAR;
          4: func = OP_PEEK_FRONT;
          default: func = OP_PEEK_REAR;
        endcase
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: value = 32'sh0000_0000;
          1: value = -32'sd1;
          2: value = 32'sh7fff_ffff;
          default: value = 32'sh8000_0000;
        endcase
      end else begin
        value = $urandom();
      end
      queue_op(func, value);
    end
  endtask

  task automatic drain();
    while (ops_to_send.size() != 0 || in_valid || results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_ready) begin
        if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_func <= ops_to_send[0].func;
          in_value <= ops_to_send[0].value;
          ops_to_send.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The result beat is checked before the input beat of the same edge is
  // predicted, so a stray result can never match its own operation.
  always @(posedge clk) begin : result_check
    deq_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing pending: data %h status %0d occupancy %0d",
                   $realtime, out_data, out_status, out_occupancy);
          bad_results++;
        end else begin
          want = results_due.pop_front();
          if (out_data !== want.data) begin
            $display("%0t: data expected %h actual %h", $realtime, want.data, out_data);
            bad_results++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                     out_status);
            bad_results++;
          end
          if (out_occupancy !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $realtime, want.occ,
                     out_occupancy);
            bad_results++;
          end
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(apply_deque_op(in_func, in_value));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int send_idle_by_phase[4];
    int recv_stall_by_phase[4];
    send_idle_by_phase = '{0, 56, 0, 37};
    recv_stall_by_phase = '{0, 0, 56, 37};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Empty deque: every read reports empty, unused codes do nothing.
    queue_op(OP_POP_FRONT, 32'sd11);
    queue_op(OP_POP_REAR, 32'sd12);
    queue_op(OP_PEEK_FRONT, 32'sd13);
    queue_op(OP_PEEK_REAR, 32'sd14);
    queue_op(OP_UNUSED_6, 32'sd15);
    queue_op(OP_UNUSED_7, -32'sd16);
    // Front push wraps the head below zero; the rear pop then wraps the tail.
    queue_op(OP_PUSH_FRONT, 32'sh1234_5678);
    queue_op(OP_POP_REAR, 32'sd0);
    queue_op(OP_PUSH_FRONT, 32'sh7fff_ffff);
    queue_op(OP_PUSH_REAR, 32'sh8000_0000);
    queue_op(OP_PEEK_FRONT, 32'sd0);
    queue_op(OP_PEEK_REAR, 32'sd0);
    queue_op(OP_PUSH_FRONT, 32'sd0);
    queue_op(OP_PUSH_REAR, -32'sd1);
    queue_op(OP_PUSH_REAR, 32'sh5555_5555);
    queue_op(OP_PUSH_REAR, 32'shaaaa_aaaa);
    queue_op(OP_PUSH_REAR, 32'sd1);
    queue_op(OP_PUSH_REAR, -32'sd2);
    // Full deque: both pushes are rejected.
    queue_op(OP_PUSH_FRONT, 32'sh0f0f_0f0f);
    queue_op(OP_PUSH_REAR, 32'shf0f0_f0f0);
    queue_op(OP_UNUSED_7, 32'sd3);
    queue_op(OP_POP_FRONT, 32'sd0);
    queue_op(OP_POP_REAR, 32'sd0);

    // Each phase drains completely before the next, so the sender sits
    // still until every outstanding beat has come back.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_idle_by_phase[p];
      recv_stall_pct = recv_stall_by_phase[p];
      queue_random_ops((p == 0) ? 365 : 390);
      drain();
    end

    repeat (10) @(negedge clk);
    if (bad_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
